// ===== rtl/sliding_window_duplicate_filter_assert.svh =====
// Assertion macros used by the duplicate filter top level.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef SLIDING_WINDOW_DUPLICATE_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_DUPLICATE_FILTER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define SWDF_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/swdf_pkg.sv =====
// Shared constants and types for the sliding-window duplicate filter.
// Used by swdf_cell, swdf_row and the top level; depends on nothing.
`default_nettype none

package swdf_pkg;

	localparam int WINDOW_BITS = 256;
	localparam int SEQ_BITS    = 24;
	localparam int FRAG_W      = 8;
	localparam int BASE_W      = SEQ_BITS + 1;
	localparam int IDX_W       = $clog2(WINDOW_BITS);
	localparam int CNT_W       = IDX_W - 1;
	localparam int HALF        = WINDOW_BITS / 2;
	localparam int SPAN_W      = 9;
	localparam int GROUP_SIZE  = 16;
	localparam int GROUP_CNT   = WINDOW_BITS / GROUP_SIZE;

	localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(4 * 8);
	localparam logic [SPAN_W-1:0] SPAN_MAX   = SPAN_W'(WINDOW_BITS);

	localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [1:0] VERDICT_DUP    = 2'd1;
	localparam logic [1:0] VERDICT_DROP   = 2'd2;

	// Command broadcast to every cell of the row in each cycle.
	typedef struct packed {
		logic             clear_all;
		logic             shift;
		logic             set_en;
		logic [IDX_W-1:0] idx;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_duplicate_filter.sv =====
// A request outside the window goes from check straight to done; a duplicate inside passes
// check and two lookup states to done; any other inside then advances the base over a run of
// set bits, or forces it forward by c positions (c may be 0), before it reaches done.
// Throughput: one request at a time; the next is accepted the cycle after the result enters the
// output register, which waits while an earlier result is held off. Reset (arst_n low,
// asynchronous): base 0, bitmap clear, accept_span 32, no result pending.
`default_nettype none

`include "sliding_window_duplicate_filter_assert.svh"

module sliding_window_duplicate_filter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [swdf_pkg::SPAN_W-1:0] cfg_wdata,   // accept_span
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [31:0]                 s_tdata,     // seq_number[23:0], fragment_number[31:24]
	input  wire logic                        s_tuser,     // op
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [31:0]                      m_tdata,     // base_after[24:0], zero fill
	output logic [2:0]                       m_tuser      // verdict[1:0], dup_in_window[2]
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_LOOK0 = 3'd2;
	localparam logic [2:0] S_LOOK1 = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;
	localparam logic [2:0] S_FORCE = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	localparam int CMP_W = swdf_pkg::BASE_W + 1;

	logic [2:0]                        state_q;
	logic [swdf_pkg::SPAN_W-1:0]       span_q;
	logic [swdf_pkg::BASE_W-1:0]       base_q;
	logic [swdf_pkg::SEQ_BITS-1:0]     sn_q;
	logic [swdf_pkg::FRAG_W-1:0]       frn_q;
	logic [swdf_pkg::IDX_W-1:0]        off_q;
	logic [swdf_pkg::CNT_W-1:0]        cnt_q;
	logic [1:0]                        verdict_q;
	logic                              dup_q;
	logic                              out_valid_q;
	logic [1:0]                        out_verdict_q;
	logic                              out_dup_q;
	logic [swdf_pkg::BASE_W-1:0]       out_base_q;

	logic                              accept;
	logic [swdf_pkg::SPAN_W-1:0]       span_c;
	logic [CMP_W-1:0]                  sn_ext;
	logic [CMP_W-1:0]                  base_ext;
	logic [CMP_W-1:0]                  limit;
	logic [CMP_W-1:0]                  diff;
	logic                              beyond;
	logic                              below;
	logic                              frag0;
	logic                              is_dup;
	logic                              shift_en;
	logic                              out_free;
	logic                              base_bit;
	logic                              seen;
	swdf_pkg::cell_cmd_t               cmd;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign span_c   = (span_q > swdf_pkg::SPAN_MAX) ? swdf_pkg::SPAN_MAX : span_q;
	assign sn_ext   = CMP_W'(sn_q);
	assign base_ext = CMP_W'(base_q);
	assign limit    = base_ext + CMP_W'(span_c);
	assign diff     = sn_ext - base_ext;
	assign beyond   = (sn_ext >= limit);
	assign below    = (sn_ext < base_ext);
	assign frag0    = (frn_q == '0);
	assign is_dup   = seen && frag0;

	assign shift_en = ((state_q == S_RUN) && base_bit) ||
		((state_q == S_FORCE) && (cnt_q != '0));

	always_comb begin
		cmd           = '0;
		cmd.idx       = off_q;
		cmd.clear_all = accept && s_tuser;
		cmd.shift     = shift_en;
		cmd.set_en    = (state_q == S_LOOK1) && !is_dup;
	end

	swdf_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.base_bit (base_bit),
		.seen     (seen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= swdf_pkg::SPAN_RESET;
		end else if (cfg_we) begin
			span_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (shift_en) begin
				base_q <= base_q + swdf_pkg::BASE_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							base_q <= swdf_pkg::BASE_W'(s_tdata[23:0]);
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					priority if (beyond || below) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LOOK0;
					end
				end
				S_LOOK0: state_q <= S_LOOK1;
				S_LOOK1: begin
					priority if (is_dup) begin
						state_q <= S_DONE;
					end else if (off_q == '0) begin
						state_q <= S_RUN;
					end else begin
						state_q <= S_FORCE;
					end
				end
				S_RUN: begin
					if (!base_bit) begin
						state_q <= S_DONE;
					end
				end
				S_FORCE: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request payload, verdict and the result slot need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			sn_q  <= s_tdata[23:0];
			frn_q <= s_tdata[31:24];
		end
		if (state_q == S_CHECK) begin
			off_q <= diff[swdf_pkg::IDX_W-1:0];
			dup_q <= 1'b0;
			priority if (beyond) begin
				verdict_q <= swdf_pkg::VERDICT_DROP;
			end else if (below) begin
				verdict_q <= frag0 ? swdf_pkg::VERDICT_DUP : swdf_pkg::VERDICT_ACCEPT;
			end else begin
				verdict_q <= swdf_pkg::VERDICT_ACCEPT;
			end
		end
		if (state_q == S_LOOK1) begin
			if (is_dup) begin
				verdict_q <= swdf_pkg::VERDICT_DUP;
				dup_q     <= 1'b1;
			end
			// Only the part of the distance beyond half the bitmap is forced forward.
			if (off_q > swdf_pkg::IDX_W'(swdf_pkg::HALF)) begin
				cnt_q <= swdf_pkg::CNT_W'(off_q - swdf_pkg::IDX_W'(swdf_pkg::HALF));
			end else begin
				cnt_q <= '0;
			end
		end else if (shift_en && (state_q == S_FORCE)) begin
			cnt_q <= cnt_q - swdf_pkg::CNT_W'(1);
		end
		if ((state_q == S_DONE) && out_free) begin
			out_verdict_q <= verdict_q;
			out_dup_q     <= dup_q;
			out_base_q    <= base_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 32'(out_base_q);
	assign m_tuser  = {out_dup_q, out_verdict_q};

	`SWDF_ASSERT_ALWAYS(a_dup_flag_verdict, clk, arst_n, !(out_valid_q && out_dup_q) || (out_verdict_q == swdf_pkg::VERDICT_DUP), "dup_in_window set without a duplicate verdict")
	`SWDF_ASSERT_NEXT(a_shift_moves_base, clk, arst_n, shift_en, base_q == swdf_pkg::BASE_W'($past(base_q) + swdf_pkg::BASE_W'(1)), "base did not advance by one on a shift")
	`SWDF_ASSERT_NEXT(a_base_holds, clk, arst_n, !shift_en && !(accept && s_tuser), $stable(base_q), "base changed without a shift or resync")
	`SWDF_ASSERT_ALWAYS(a_no_shift_idle, clk, arst_n, !shift_en || (state_q == S_RUN) || (state_q == S_FORCE), "cell row shifted outside an advance")

endmodule

`default_nettype wire

// ===== rtl/swdf_cell.sv =====
// One bit of the seen-bitmap, held relative to the window base.
// Depends on swdf_pkg for the command type and index width.
`default_nettype none

module swdf_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [swdf_pkg::IDX_W-1:0] cell_idx,
	input  wire swdf_pkg::cell_cmd_t        cmd,
	input  wire logic                       next_bit,
	output logic                            bit_out,
	output logic                            hit
);

	logic bit_q;
	logic sel;

	assign sel     = (cmd.idx == cell_idx);
	assign bit_out = bit_q;
	assign hit     = bit_q & sel;

	// A shift moves the window base up by one, so each cell takes its upper neighbor's bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else begin
			priority if (cmd.clear_all) begin
				bit_q <= 1'b0;
			end else if (cmd.shift) begin
				bit_q <= next_bit;
			end else if (cmd.set_en && sel) begin
				bit_q <= 1'b1;
			end else begin
				bit_q <= bit_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/swdf_row.sv =====
// Row of bitmap cells chained base-first, with a registered OR tree for lookups.
// Depends on swdf_pkg and swdf_cell.
`default_nettype none

module swdf_row (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire swdf_pkg::cell_cmd_t cmd,
	output logic                     base_bit,
	output logic                     seen
);

	logic [swdf_pkg::WINDOW_BITS-1:0] bits;
	logic [swdf_pkg::WINDOW_BITS-1:0] hits;
	logic [swdf_pkg::WINDOW_BITS-1:0] nbr;
	logic [swdf_pkg::GROUP_CNT-1:0]   grp_q;

	assign nbr = {1'b0, bits[swdf_pkg::WINDOW_BITS-1:1]};

	for (genvar i = 0; i < swdf_pkg::WINDOW_BITS; i++) begin : g_cell
		swdf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (swdf_pkg::IDX_W'(i)),
			.cmd      (cmd),
			.next_bit (nbr[i]),
			.bit_out  (bits[i]),
			.hit      (hits[i])
		);
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < swdf_pkg::GROUP_CNT; g++) begin
			grp_q[g] <= |hits[g*swdf_pkg::GROUP_SIZE +: swdf_pkg::GROUP_SIZE];
		end
	end

	assign base_bit = bits[0];
	assign seen     = |grp_q;

endmodule

`default_nettype wire
